@@ rtl/sfe_pkg.sv @@
// shared types and constants of the stuffed frame encoder
package sfe_pkg;

   localparam int BYTE_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int NUM_PHASES  = 8;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STOP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PAD   = 2'd2;

   localparam logic [BYTE_W-1:0] START_RESET = 8'h02;
   localparam logic [BYTE_W-1:0] STOP_RESET  = 8'h03;
   localparam logic [BYTE_W-1:0] PAD_RESET   = 8'h10;

   // output words an item can produce, in line order
   typedef enum logic [2:0] {
      PH_START_A = 3'd0,
      PH_START_B = 3'd1,
      PH_DATA    = 3'd2,
      PH_DATA_PAD = 3'd3,
      PH_CHECK   = 3'd4,
      PH_CHECK_PAD = 3'd5,
      PH_STOP_A  = 3'd6,
      PH_STOP_B  = 3'd7
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start_char;
      logic [BYTE_W-1:0] stop_char;
      logic [BYTE_W-1:0] pad_char;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic              need_start;
      logic [BYTE_W-1:0] data;
      logic              data_stuff;
      logic              last;
      logic [BYTE_W-1:0] check;
      logic              check_stuff;
   } cmd_type;

endpackage

@@ rtl/sfe_if.sv @@
// channel interfaces of the stuffed frame encoder

interface sfe_req_if;
   logic                       valid;
   logic                       ready;
   logic [sfe_pkg::BYTE_W-1:0] data_byte;
   logic                       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sfe_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [sfe_pkg::BYTE_W-1:0] out_byte;
   logic                       run_last;
   logic                       frame_done;

   modport source (output valid, output out_byte, output run_last, output frame_done,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input frame_done,
                 output ready);
endinterface

interface sfe_csr_if;
   logic                          valid;
   logic                          ready;
   logic [sfe_pkg::CSR_IDX_W-1:0] index;
   logic [sfe_pkg::BYTE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/sfe_front.sv @@
// front end: accepts content words, tracks frame state and checksum, classifies
module sfe_front (
   input  logic             clock,
   input  logic             reset,
   input  sfe_pkg::cfg_type cfg,
   sfe_req_if.sink          req_if,
   output sfe_pkg::cmd_type push_cmd,
   output logic             push_valid,
   input  logic             push_ready
);
   import sfe_pkg::*;

   logic              in_frame_ff, in_frame_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] sum_next;
   logic [BYTE_W-1:0] check;
   logic              accept;

   assign req_if.ready = push_ready;
   assign push_valid   = req_if.valid;
   assign accept       = req_if.valid && push_ready;

   // sum restarts with each frame
   assign sum_next = (in_frame_ff ? sum_ff : '0) + req_if.data_byte;
   assign check    = BYTE_W'(~sum_next + 1'b1);

   always_comb begin
      push_cmd.need_start  = !in_frame_ff;
      push_cmd.data        = req_if.data_byte;
      push_cmd.data_stuff  = (req_if.data_byte == cfg.start_char) ||
                             (req_if.data_byte == cfg.stop_char);
      push_cmd.last        = req_if.last_byte;
      push_cmd.check       = check;
      push_cmd.check_stuff = (check == cfg.start_char) || (check == cfg.stop_char);

      in_frame_in = in_frame_ff;
      sum_in      = sum_ff;
      if (accept) begin
         in_frame_in = !req_if.last_byte;
         sum_in      = req_if.last_byte ? '0 : sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         sum_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         sum_ff      <= sum_in;
      end
   end

endmodule

@@ rtl/sfe_queue.sv @@
// short command queue between front and back
module sfe_queue #(
   parameter int DEPTH = sfe_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  sfe_pkg::cmd_type push_cmd,
   input  logic             push_valid,
   output logic             push_ready,
   output sfe_pkg::cmd_type pop_cmd,
   output logic             pop_valid,
   input  logic             pop_ready
);
   import sfe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/sfe_back.sv @@
// back end: steps through the words of each command into the output register
module sfe_back (
   input  logic             clock,
   input  logic             reset,
   input  sfe_pkg::cfg_type cfg,
   input  sfe_pkg::cmd_type pop_cmd,
   input  logic             pop_valid,
   output logic             pop_ready,
   sfe_rsp_if.source        rsp_if
);
   import sfe_pkg::*;

   logic [NUM_PHASES-1:0] mask;
   logic [NUM_PHASES-1:0] done_ff, done_in;
   logic [NUM_PHASES-1:0] remain;
   logic [NUM_PHASES-1:0] cur_onehot;
   phase_type             cur_phase;
   logic                  is_last;
   logic                  can_load;
   logic                  emit;
   logic [BYTE_W-1:0]     cur_byte;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              run_last_ff;
   logic              frame_done_ff;

   // words the head command needs
   always_comb begin
      mask[PH_START_A]   = pop_cmd.need_start;
      mask[PH_START_B]   = pop_cmd.need_start;
      mask[PH_DATA]      = 1'b1;
      mask[PH_DATA_PAD]  = pop_cmd.data_stuff;
      mask[PH_CHECK]     = pop_cmd.last;
      mask[PH_CHECK_PAD] = pop_cmd.last && pop_cmd.check_stuff;
      mask[PH_STOP_A]    = pop_cmd.last;
      mask[PH_STOP_B]    = pop_cmd.last;
   end

   assign remain = mask & ~done_ff;

   // lowest pending word goes next
   always_comb begin
      cur_phase = PH_STOP_B;
      for (int i = NUM_PHASES - 1; i >= 0; i--) begin
         if (remain[i]) begin
            cur_phase = phase_type'(i[2:0]);
         end
      end
   end

   assign cur_onehot = NUM_PHASES'(1) << cur_phase;
   assign is_last    = ((remain & ~cur_onehot) == '0);
   assign can_load   = !valid_ff || rsp_if.ready;
   assign emit       = pop_valid && can_load;
   assign pop_ready  = emit && is_last;

   always_comb begin
      unique case (cur_phase)
         PH_START_A, PH_START_B:  cur_byte = cfg.start_char;
         PH_DATA:                 cur_byte = pop_cmd.data;
         PH_CHECK:                cur_byte = pop_cmd.check;
         PH_DATA_PAD, PH_CHECK_PAD: cur_byte = cfg.pad_char;
         PH_STOP_A, PH_STOP_B:    cur_byte = cfg.stop_char;
         default:                 cur_byte = cfg.stop_char;
      endcase
   end

   always_comb begin
      done_in  = done_ff;
      valid_in = valid_ff;
      if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
      if (emit) begin
         valid_in = 1'b1;
         done_in  = is_last ? '0 : (done_ff | cur_onehot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff       <= cur_byte;
         run_last_ff   <= is_last;
         frame_done_ff <= (cur_phase == PH_STOP_B);
      end
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.out_byte   = byte_ff;
   assign rsp_if.run_last   = run_last_ff;
   assign rsp_if.frame_done = frame_done_ff;

endmodule

@@ rtl/stuffed_frame_encoder_with_checksum.sv @@
// top level of the byte-stuffing frame encoder with sum checksum
//
//   channel  dir  payload                              handshake
//   req_if   in   data_byte[8], last_byte              valid/ready
//   rsp_if   out  out_byte[8], run_last, frame_done    valid/ready
//   csr_if   in   index[2], data[8]                    valid/ready (always ready)
//
// one output word per cycle while rsp ready is high; an item yields 1 line word
// for a plain middle byte up to 8 for a one-byte frame, set by the back end
// sequencer. a new word is accepted every cycle while the command queue
// (QUEUE_DEPTH entries) has room. reset clears frame state, checksum, queue and
// output register, and loads start 0x02, stop 0x03, pad 0x10. low rsp ready
// holds the output register; the queue then fills and req ready drops.
module stuffed_frame_encoder_with_checksum #(
   parameter int QUEUE_DEPTH = sfe_pkg::QUEUE_DEPTH
) (
   input logic     clock,
   input logic     reset,
   sfe_req_if.sink   req_if,
   sfe_rsp_if.source rsp_if,
   sfe_csr_if.sink   csr_if
);
   import sfe_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type push_cmd;
   logic    push_valid, push_ready;
   cmd_type pop_cmd;
   logic    pop_valid, pop_ready;

   // the config register takes a write whenever one is offered, so the port never stalls
   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            REG_START: cfg_in.start_char = csr_if.data;
            REG_STOP:  cfg_in.stop_char  = csr_if.data;
            REG_PAD:   cfg_in.pad_char   = csr_if.data;
            default:   cfg_in = cfg_ff;   // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_char <= START_RESET;
         cfg_ff.stop_char  <= STOP_RESET;
         cfg_ff.pad_char   <= PAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: frame state, running sum, delimiter match
   sfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_if     (req_if),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   // decouples accept from emission
   sfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_cmd    (pop_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   // back: one line word per cycle into the output register, while it is empty or rsp ready is high
   sfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_cmd   (pop_cmd),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

   // closing word always ends the item's run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.frame_done |-> rsp_if.run_last)
      else $error("frame_done without run_last");

   // closing word carries the stop character
   a_done_is_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.frame_done |-> rsp_if.out_byte == cfg_ff.stop_char)
      else $error("frame_done on a non-stop word");

   // output register empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("output valid after reset");

endmodule

@@ tb/sfe_line_checker.sv @@
// checker of the stuffed frame encoder: predicts line words and compares them
module sfe_line_checker (
   input  logic clock,
   input  logic reset,
   sfe_req_if   req_mon,
   sfe_rsp_if   rsp_mon,
   sfe_csr_if   csr_mon,
   output int   fail_count,
   output int   words_due,
   output int   words_checked,
   output int   frames_closed
);
   timeunit 1ns;
   timeprecision 1ps;
   import sfe_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_last;
      logic              frame_done;
   } line_word_type;

   line_word_type     line_words_due[$];
   cfg_type           delims;
   logic              open_frame;
   logic [BYTE_W-1:0] content_sum;

   function automatic logic is_delim(input logic [BYTE_W-1:0] b);
      return (b == delims.start_char) || (b == delims.stop_char);
   endfunction

   // line words caused by one content byte, queued in line order
   function automatic void encode_byte(input logic [BYTE_W-1:0] data, input logic last);
      line_word_type     words [8];
      int                n;
      logic [BYTE_W-1:0] check;
      n = 0;
      if (!open_frame) begin
         words[0] = '{delims.start_char, 1'b0, 1'b0};
         words[1] = words[0];
         n = 2;
         open_frame = 1'b1;
         content_sum = '0;
      end
      words[n] = '{data, 1'b0, 1'b0};
      n++;
      if (is_delim(data)) begin
         words[n] = '{delims.pad_char, 1'b0, 1'b0};
         n++;
      end
      content_sum = content_sum + data;
      if (last) begin
         check = 8'hff - content_sum + 8'h01;
         words[n] = '{check, 1'b0, 1'b0};
         n++;
         if (is_delim(check)) begin
            words[n] = '{delims.pad_char, 1'b0, 1'b0};
            n++;
         end
         words[n]   = '{delims.stop_char, 1'b0, 1'b0};
         words[n+1] = '{delims.stop_char, 1'b0, 1'b1};
         n += 2;
         open_frame = 1'b0;
         content_sum = '0;
      end
      words[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) line_words_due.push_back(words[i]);
   endfunction

   task automatic flag_fault(input string what, input line_word_type want,
                             input line_word_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%t %s: expected byte %02h last %b done %b, got byte %02h last %b done %b",
                  $realtime, what, want.out_byte, want.run_last, want.frame_done,
                  got.out_byte, got.run_last, got.frame_done);
   endtask

   always @(posedge clock) begin : watch
      line_word_type got;
      line_word_type want;
      if (reset) begin
         line_words_due.delete();
         delims = '{START_RESET, STOP_RESET, PAD_RESET};
         open_frame = 1'b0;
         content_sum = '0;
      end else begin
         // a word accepted at this edge still sees the old registers
         if (req_mon.valid && req_mon.ready)
            encode_byte(req_mon.data_byte, req_mon.last_byte);
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_START: delims.start_char = csr_mon.data;
               REG_STOP:  delims.stop_char  = csr_mon.data;
               REG_PAD:   delims.pad_char   = csr_mon.data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.out_byte, rsp_mon.run_last, rsp_mon.frame_done};
            words_checked++;
            if (got.frame_done) frames_closed++;
            if (line_words_due.size() == 0) begin
               flag_fault("word with nothing expected", '0, got);
            end else begin
               want = line_words_due.pop_front();
               if (got.out_byte !== want.out_byte)
                  flag_fault("out_byte mismatch", want, got);
               else if (got.run_last !== want.run_last)
                  flag_fault("run_last mismatch", want, got);
               else if (got.frame_done !== want.frame_done)
                  flag_fault("frame_done mismatch", want, got);
            end
         end
      end
      words_due = line_words_due.size();
   end

endmodule

@@ tb/testbench.sv @@
// top of the stuffed frame encoder testbench: clock, reset, stimulus and verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sfe_pkg::*;

   // index past the register list, the block must drop writes to it
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int LONG_HOLD       = 300;   // receiver hold-off that fills the block
   localparam int DRAIN_PAUSE     = 16;    // settling pause after a drain
   localparam int ITEMS_PER_PHASE = 34;

   logic clock;
   logic reset;

   sfe_req_if req_ch ();
   sfe_rsp_if rsp_ch ();
   sfe_csr_if csr_ch ();

   int fail_count;
   int words_due;
   int words_checked;
   int frames_closed;

   // knobs shared by the stimulus and the line sink
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int items_sent    = 0;

   // delimiters as last written, used to aim content bytes at them
   logic [BYTE_W-1:0] cur_start = START_RESET;
   logic [BYTE_W-1:0] cur_stop  = STOP_RESET;
   logic [BYTE_W-1:0] cur_pad   = PAD_RESET;

   stuffed_frame_encoder_with_checksum DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   sfe_line_checker line_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_mon       (csr_ch),
      .fail_count    (fail_count),
      .words_due     (words_due),
      .words_checked (words_checked),
      .frames_closed (frames_closed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // line sink: random stalls, plus a long hold-off counted here when asked for
   initial begin : line_sink
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // offer one content word; valid stays high afterwards so back-to-back words flow
   task automatic send_item(input logic [BYTE_W-1:0] data, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= data;
      req_ch.last_byte <= last;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // stop offering, wait until every predicted line word is back, then let the block settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (words_due == 0);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // all three delimiters, then a junk write to the unused index that must be dropped
   task automatic set_delimiters(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] t,
                                 input logic [BYTE_W-1:0] p);
      write_reg(REG_START, s);
      write_reg(REG_STOP, t);
      write_reg(REG_PAD, p);
      write_reg(REG_UNUSED, 8'($urandom_range(255)));
      csr_ch.valid <= 1'b0;
      cur_start = s;
      cur_stop  = t;
      cur_pad   = p;
   endtask

   // content bytes lean toward the delimiters so stuffing is hit often
   function automatic logic [BYTE_W-1:0] pick_byte();
      int r;
      r = $urandom_range(99);
      if (r < 10) return cur_start;
      if (r < 20) return cur_stop;
      if (r < 25) return cur_pad;
      return 8'($urandom_range(255));
   endfunction

   initial begin : stimulus
      int phase_items;
      int frm_bytes;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.last_byte = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = REG_START;
      csr_ch.data      = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset delimiters: one-byte frame with a zero sum
      send_item(8'h00, 1'b1);
      // extremes, both delimiters and the pad value as content (pad itself is not stuffed)
      send_item(8'hff, 1'b0);
      send_item(8'h02, 1'b0);
      send_item(8'h03, 1'b0);
      send_item(8'h10, 1'b0);
      send_item(8'h80, 1'b1);
      // checksum landing on start, then on stop, so it gets a pad word
      send_item(8'hfe, 1'b1);
      send_item(8'hfd, 1'b1);
      // open a frame, change stop while it is open, then close it with the new stop value
      send_item(8'h55, 1'b0);
      send_item(8'haa, 1'b0);
      send_item(8'h11, 1'b0);
      drain();
      set_delimiters(START_RESET, 8'h11, PAD_RESET);
      send_item(8'h11, 1'b1);
      drain();

      // start equal to stop, pad equal to both: single pad per match, pad never stuffed
      set_delimiters(8'h80, 8'h80, 8'h80);
      send_item(8'h80, 1'b1);    // longest case, eight line words
      send_item(8'h7f, 1'b0);
      send_item(8'h01, 1'b1);
      send_item(8'h00, 1'b1);

      // random frames under four delimiter settings and four idle mixes
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         case (ph)
            0: begin
               set_delimiters(8'h00, 8'hff, 8'h01);
               send_idle_pct = 0;
               stall_pct     = 0;
               hold_requests++;    // long receiver hold while the sender keeps going
            end
            1: begin
               set_delimiters(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
               send_idle_pct = 49;
               stall_pct     = 0;
            end
            2: begin
               set_delimiters(8'hff, 8'h00, 8'hff);
               send_idle_pct = 0;
               stall_pct     = 49;
            end
            default: begin
               set_delimiters(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
               send_idle_pct = 28;
               stall_pct     = 28;
            end
         endcase
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            // mostly short frames, now and then a long one
            frm_bytes = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
            for (int k = 0; k < frm_bytes; k++) begin
               send_item(pick_byte(), k == frm_bytes - 1);
               phase_items++;
            end
         end
      end
      drain();

      $display("summary: %0d content words in %0d closed frames, %0d line words checked",
               items_sent, frames_closed, words_checked);
      $display("summary: seven delimiter settings, mid-frame write, idle mixes and a %0d-cycle hold",
               LONG_HOLD);
      if (fail_count == 0 && words_due == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
